/* rtl/button_edge_repeat_action_encoder_assert.svh */
// Assertion shorthands shared by the encoder RTL.
// Each expects clk and rst_n in scope and is quiet while reset is held.
`ifndef BUTTON_EDGE_REPEAT_ACTION_ENCODER_ASSERT_SVH
`define BUTTON_EDGE_REPEAT_ACTION_ENCODER_ASSERT_SVH

// Same-cycle implication
`define BERA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BERA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bera_pkg.sv */
package bera_pkg;

  localparam int BUTTON_COUNT = 10;
  localparam int DELAY_W      = 8;
  localparam int CFG_INDEX_W  = 2;

  // Button bit positions
  localparam int BTN_UP     = 0;
  localparam int BTN_DOWN   = 1;
  localparam int BTN_LEFT   = 2;
  localparam int BTN_RIGHT  = 3;
  localparam int BTN_A      = 4;
  localparam int BTN_B      = 5;
  localparam int BTN_START  = 6;
  localparam int BTN_SELECT = 7;
  localparam int BTN_MENU   = 8;
  localparam int BTN_QUIT   = 9;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DELAY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEXT_DELAY  = 2'd1;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 8'd15;
  localparam logic [DELAY_W-1:0] NEXT_DELAY_RST  = 8'd7;

  typedef logic [BUTTON_COUNT-1:0] buttons_t;
  typedef logic [DELAY_W-1:0]      delay_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_UP       = 4'd1,
    ACT_DOWN     = 4'd2,
    ACT_LEFT     = 4'd3,
    ACT_RIGHT    = 4'd4,
    ACT_CANCEL   = 4'd5,
    ACT_OK       = 4'd6,
    ACT_START    = 4'd7,
    ACT_SETTINGS = 4'd8,
    ACT_QUIT     = 4'd9
  } action_t;

  // Triggered set and repeat status for one frame
  typedef struct packed {
    buttons_t trig;
    logic     fired;
  } trig_t;

endpackage

/* rtl/bera_repeat.sv */
module bera_repeat
  import bera_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  buttons_t held,
  input  delay_t   first_delay,
  input  delay_t   next_delay,
  output trig_t    result
);

  buttons_t prev_r, prev_nxt;
  logic     armed_r, armed_nxt;
  logic     first_r, first_nxt;
  delay_t   cnt_r, cnt_nxt;

  logic     do_hold;
  delay_t   cnt_eff;
  logic     fire;

  // Hold frame: a direction down and neither menu nor quit
  assign do_hold = (|held[BTN_RIGHT:BTN_UP]) && !held[BTN_MENU] && !held[BTN_QUIT];

  // Load the delay on arming, else keep counting
  assign cnt_eff = armed_r ? cnt_r : (first_r ? first_delay : next_delay);
  assign fire    = do_hold && (cnt_eff == '0);

  assign result.trig  = fire ? held : (held & ~prev_r);
  assign result.fired = fire;

  // Next state, committed only when the beat advances
  always_comb begin
    prev_nxt  = prev_r;
    armed_nxt = armed_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    if (adv) begin
      prev_nxt  = held;
      armed_nxt = do_hold && !fire;
      first_nxt = !do_hold;
      if (do_hold) begin
        cnt_nxt = fire ? cnt_eff : cnt_eff - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      armed_r <= 1'b0;
      first_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      prev_r  <= prev_nxt;
      armed_r <= armed_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`include "button_edge_repeat_action_encoder_assert.svh"

  `BERA_ASSERT_NXT(a_fire_disarms, adv && fire, !armed_r, "repeat fired but still armed")
  `BERA_ASSERT_NXT(a_release_rearms_first, adv && !do_hold, first_r && !armed_r,
    "released hold did not restore first-hold state")
  `BERA_ASSERT_NXT(a_count_down, adv && do_hold && armed_r && (cnt_r != '0),
    cnt_r == $past(cnt_r) - 1'b1, "hold countdown did not decrement")

endmodule

/* rtl/bera_prio.sv */
module bera_prio
  import bera_pkg::*;
(
  input  buttons_t trig,
  output action_t  action
);

  // Pick one action; B outranks A, menu alone gives none
  always_comb begin
    if (trig[BTN_UP])          action = ACT_UP;
    else if (trig[BTN_DOWN])   action = ACT_DOWN;
    else if (trig[BTN_LEFT])   action = ACT_LEFT;
    else if (trig[BTN_RIGHT])  action = ACT_RIGHT;
    else if (trig[BTN_B])      action = ACT_CANCEL;
    else if (trig[BTN_A])      action = ACT_OK;
    else if (trig[BTN_START])  action = ACT_START;
    else if (trig[BTN_SELECT]) action = ACT_SETTINGS;
    else if (trig[BTN_QUIT])   action = ACT_QUIT;
    else                       action = ACT_NONE;
  end

endmodule

/* rtl/button_edge_repeat_action_encoder.sv */
// Button edge / typematic repeat / action encoder.
// Input channel: one beat per frame carries in_buttons, the held state of
// ten navigation buttons, on in_valid/in_ready.
// Result channel: one beat per input beat carries out_action (priority-
// encoded menu action), out_menu_edge and out_repeat_fired on
// out_valid/out_ready.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (0 first repeat delay, 1 next repeat delay); other indexes are dropped.
// Write only while no beat is in flight.
// Path: a beat accepted into the input register passes the repeat and
// priority logic into the result register when that register is free.
// Throughput is one beat per cycle while out_ready holds, set by the
// two-register path: input -> repeat/priority logic -> result register.
// When the receiver stalls the result register holds, the input register
// fills, and in_ready drops until the result is taken.
// Reset: clears both registers' valid flags and the repeat state, and loads
// delays of 15 and 7 frames.
module button_edge_repeat_action_encoder
  import bera_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [9:0]             in_buttons,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_action,
  output logic                   out_menu_edge,
  output logic                   out_repeat_fired,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]     cfg_wdata
);

  delay_t   first_delay_r, next_delay_r;
  logic     s1_valid_r, s1_valid_nxt;
  buttons_t s1_buttons_r;
  logic     out_valid_r, out_valid_nxt;
  action_t  action_r;
  logic     menu_r, fired_r;

  logic     s1_move;
  trig_t    frame;
  action_t  action;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r <= FIRST_DELAY_RST;
      next_delay_r  <= NEXT_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DELAY: first_delay_r <= cfg_wdata;
        CFG_NEXT_DELAY:  next_delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance when the result register is empty or being drained
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_buttons_r <= in_buttons;
    end
  end

  bera_repeat u_repeat (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_move),
    .held        (s1_buttons_r),
    .first_delay (first_delay_r),
    .next_delay  (next_delay_r),
    .result      (frame)
  );

  bera_prio u_prio (
    .trig   (frame.trig),
    .action (action)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      action_r <= action;
      menu_r   <= frame.trig[BTN_MENU];
      fired_r  <= frame.fired;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = action_r;
  assign out_menu_edge    = menu_r;
  assign out_repeat_fired = fired_r;

`include "button_edge_repeat_action_encoder_assert.svh"

  `BERA_ASSERT_IMP(a_fire_is_direction, out_valid_r && fired_r,
    (action_r == ACT_UP) || (action_r == ACT_DOWN) || (action_r == ACT_LEFT)
    || (action_r == ACT_RIGHT), "repeat result without a direction action")
  `BERA_ASSERT_IMP(a_fire_no_menu, out_valid_r && fired_r, !menu_r,
    "repeat fired with menu held")
  `BERA_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_move, s1_valid_r,
    "input register dropped a stalled beat")

endmodule
